/* rtl/aes_pkg.sv */
// Shared types, constants and the short-segment coverage table of the edge segment block.
`timescale 1ns / 1ps

package aes_pkg;

	// Longest segment in pixels; longer requests saturate to it.
	localparam int MAX_SEG_LEN = 64;
	localparam int LEN_W       = $clog2(MAX_SEG_LEN + 1);
	localparam int IDX_W       = $clog2(MAX_SEG_LEN);

	// Segments shorter than this use the coverage table.
	localparam int SHORT_LEN   = 8;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);

	// Beat widths on the two streams.
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 72;

	// Steps of the bit-serial divider, one per dividend bit.
	localparam int DIV_STEPS   = 8;
	localparam int DCNT_W      = $clog2(DIV_STEPS);

	// Classified segment request as it travels through the queue.
	typedef struct packed {
		logic              dir;
		logic              inv;
		logic              short_seg;
		logic [LEN_W-1:0]  len;
		logic [15:0]       x;
		logic [15:0]       y;
		logic [7:0]        base;
		logic [31:0]       color;
	} seg_req_t;

	// Sequencer states of the back end.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_RUN
	} back_state_t;

	// Coverage of pixel i of a segment of length L, for L from 1 to 7, rows packed.
	localparam logic [7:0] COV_TAB [28] = '{
		8'd128,
		8'd64,  8'd192,
		8'd42,  8'd128, 8'd212,
		8'd32,  8'd96,  8'd159, 8'd223,
		8'd26,  8'd76,  8'd128, 8'd178, 8'd230,
		8'd21,  8'd64,  8'd106, 8'd148, 8'd191, 8'd234,
		8'd18,  8'd55,  8'd91,  8'd128, 8'd164, 8'd200, 8'd237
	};

	// Table lookup for a short segment; the row of length L starts at L*(L-1)/2.
	function automatic logic [7:0] cov_lookup(input logic [2:0] len, input logic [2:0] idx);
		logic [4:0] row;
		begin
			unique case (len)
				3'd2:    row = 5'd1;
				3'd3:    row = 5'd3;
				3'd4:    row = 5'd6;
				3'd5:    row = 5'd10;
				3'd6:    row = 5'd15;
				3'd7:    row = 5'd21;
				default: row = 5'd0;
			endcase
			cov_lookup = COV_TAB[row + 5'(idx)];
		end
	endfunction

endpackage

/* rtl/antialias_edge_segment.sv */
// Top level of the anti-aliasing edge segment expander.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one segment request per beat; tuser carries the direction
// (0 steps y, 1 steps x). The master stream gives one pixel beat per pixel of the
// segment, with tlast on the final pixel; a zero-length request is taken and yields
// no beat. Lengths beyond MAX_SEG_LEN saturate and coordinates wrap in 16 bits.
// Requests are classified on entry and held in a two-entry queue, so the slave side
// keeps taking requests while the back end expands earlier ones.
// A segment of 1 to 7 pixels is set up as the back end takes it from the queue; a
// longer one then runs the 8-step bit-serial divider, once per segment, and a
// preparation step. After that the back end emits one pixel per cycle while the
// receiver does not stall, and a request occupies it until its last pixel is out.
// When the receiver stalls, the pixel in the output register holds and stepping
// pauses; the queue fills and tready on the slave side falls only when it is full.
// Reset empties the queue and the output register; no request is pending after it.
module antialias_edge_segment (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// start_x[15:0], start_y[31:16], seg_length[39:32], base_opacity[47:40],
	// pixel_color[79:48]
	input  logic [aes_pkg::IN_DATA_W-1:0]   s_tdata,
	// direction[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_x[15:0], pixel_y[31:16], pixel_opacity[39:32], color_out[71:40]
	output logic [aes_pkg::OUT_DATA_W-1:0]  m_tdata,
	// last_pixel
	output logic                            m_tlast
);
	import aes_pkg::*;

	logic     push;
	logic     push_ready;
	seg_req_t push_req;
	logic     q_valid;
	logic     q_pop;
	seg_req_t q_req;

	aes_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_ready (push_ready),
		.push_req   (push_req)
	);

	aes_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_ready (push_ready),
		.wr_data  (push_req),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_data  (q_req)
	);

	aes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (q_valid),
		.req_pop   (q_pop),
		.req       (q_req),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* rtl/aes_front.sv */
// Front end: accepts segment requests, saturates the length and classifies them.
`timescale 1ns / 1ps

module aes_front (
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [aes_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                         s_tuser,
	output logic                         push,
	input  logic                         push_ready,
	output aes_pkg::seg_req_t            push_req
);
	import aes_pkg::*;

	logic [7:0] raw_len;
	logic [7:0] mag;
	logic [LEN_W-1:0] sat_len;

	assign raw_len = s_tdata[39:32];

	// Magnitude of the signed length; -128 gives 128, which fits unsigned.
	always_comb begin
		mag = raw_len[7] ? 8'(-raw_len) : raw_len;
		if (int'(mag) > MAX_SEG_LEN) begin
			sat_len = LEN_W'(MAX_SEG_LEN);
		end else begin
			sat_len = LEN_W'(mag);
		end
	end

	// Build the classified request.
	always_comb begin
		push_req.dir       = s_tuser;
		push_req.inv       = raw_len[7];
		push_req.short_seg = (int'(sat_len) < SHORT_LEN);
		push_req.len       = sat_len;
		push_req.x         = s_tdata[15:0];
		push_req.y         = s_tdata[31:16];
		push_req.base      = s_tdata[47:40];
		push_req.color     = s_tdata[79:48];
	end

	// A zero-length request is taken and dropped here.
	assign s_tready = push_ready;
	assign push     = s_tvalid && push_ready && (sat_len != '0);

endmodule

/* rtl/aes_fifo.sv */
// Short request queue between the front and the back end.
`timescale 1ns / 1ps

module aes_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	output logic              wr_ready,
	input  aes_pkg::seg_req_t wr_data,
	output logic              rd_valid,
	input  logic              rd_en,
	output aes_pkg::seg_req_t rd_data
);
	import aes_pkg::*;

	seg_req_t        slot_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = (count_q != (QA_W + 1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QA_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QA_W + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/aes_back.sv */
// Back end: divides once per long segment, then steps one pixel per unstalled cycle to the output.
`timescale 1ns / 1ps

module aes_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_pop,
	input  aes_pkg::seg_req_t              req,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [aes_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import aes_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	// Held segment.
	seg_req_t         seg_q;
	logic [IDX_W-1:0] idx_q;
	logic [DCNT_W-1:0] dcnt_q;

	// Divider: dvd_q shifts the dividend out and the quotient in.
	logic [7:0]       dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   div_sh;
	logic             div_ge;

	// Running quotient and remainder of (2i+1)*base over 2L.
	logic [7:0]       a_q;
	logic [LEN_W:0]   b_q;
	logic [7:0]       q_q;
	logic [LEN_W:0]   r_q;
	logic [LEN_W+1:0] r_sum;
	logic [LEN_W+1:0] two_len;
	logic             r_wrap;

	// Output register.
	logic             out_valid_q;
	logic [15:0]      out_x_q;
	logic [15:0]      out_y_q;
	logic [7:0]       out_opa_q;
	logic [31:0]      out_color_q;
	logic             out_last_q;

	logic             slot_free;
	logic             emit;
	logic             div_step;
	logic             is_last;
	logic [15:0]      tab_prod;
	logic [7:0]       cov;
	logic [7:0]       opa;

	assign slot_free = !out_valid_q || m_tready;
	assign is_last   = (LEN_W'(idx_q) == seg_q.len - LEN_W'(1));

	// Divider step.
	assign div_sh = {rem_q, dvd_q[7]};
	assign div_ge = (div_sh >= {1'b0, seg_q.len});

	// Remainder update with one wrap.
	assign two_len = {1'b0, seg_q.len, 1'b0};
	assign r_sum   = {1'b0, r_q} + {1'b0, b_q};
	assign r_wrap  = (r_sum >= two_len);

	// Pixel opacity, from the table or the running quotient, then inversion.
	always_comb begin
		tab_prod = 16'(cov_lookup(seg_q.len[2:0], idx_q[2:0])) * 16'(seg_q.base);
		cov      = seg_q.short_seg ? tab_prod[15:8] : q_q;
		opa      = seg_q.inv ? (seg_q.base - cov) : cov;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = req.short_seg ? ST_RUN : ST_DIV;
				end
			end
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (slot_free && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_pop  = 1'b0;
		emit     = 1'b0;
		div_step = 1'b0;
		unique case (state_q)
			ST_IDLE: req_pop  = req_valid;
			ST_DIV:  div_step = 1'b1;
			ST_PREP: ;
			ST_RUN:  emit     = slot_free;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Segment, divider and stepping datapath.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			seg_q  <= req;
			idx_q  <= '0;
			dcnt_q <= '0;
			dvd_q  <= req.base;
			rem_q  <= '0;
		end
		if (div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
			dvd_q  <= {dvd_q[6:0], div_ge};
			rem_q  <= div_ge ? LEN_W'(div_sh - {1'b0, seg_q.len}) : LEN_W'(div_sh);
		end
		// base = Q*L + R gives 2*base = Q*2L + 2R and base = (Q>>1)*2L + (Q odd ? L+R : R).
		if (state_q == ST_PREP) begin
			a_q <= dvd_q;
			b_q <= {rem_q, 1'b0};
			q_q <= {1'b0, dvd_q[7:1]};
			r_q <= dvd_q[0] ? ({1'b0, seg_q.len} + {1'b0, rem_q}) : {1'b0, rem_q};
		end
		if (emit) begin
			idx_q <= idx_q + IDX_W'(1);
			if (seg_q.dir) begin
				seg_q.x <= seg_q.x + 16'd1;
			end else begin
				seg_q.y <= seg_q.y + 16'd1;
			end
			q_q <= q_q + a_q + 8'(r_wrap);
			r_q <= r_wrap ? (LEN_W + 1)'(r_sum - two_len) : (LEN_W + 1)'(r_sum);
			out_x_q     <= seg_q.x;
			out_y_q     <= seg_q.y;
			out_opa_q   <= opa;
			out_color_q <= seg_q.color;
			out_last_q  <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_color_q, out_opa_q, out_y_q, out_x_q};
	assign m_tlast  = out_last_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the edge segment expander: directed table, random segments, stalls.
`timescale 1ns / 1ps

module tb_top;

	import aes_pkg::*;

	// One segment request as the sender drives it. A row with known set carries its single
	// pixel opacity typed in; such rows are always one pixel long.
	typedef struct packed {
		logic        dir;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  len;
		logic [7:0]  base;
		logic [31:0] color;
		logic        known;
		logic [7:0]  known_opa;
	} seg_row_t;

	// One pixel beat as the receiver sees it.
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  opa;
		logic [31:0] color;
		logic        last;
	} pixel_t;

	localparam int BOUND_LEN  = 64;
	localparam int HOLD_LEN   = 300;
	localparam int PHASE_SEGS = 112;
	localparam int NUM_ROWS   = 25;

	// Coverage ramps for segments of 1 to 7 pixels, one row per length.
	localparam logic [7:0] RAMP_TAB [28] = '{
		8'd128,
		8'd64,  8'd192,
		8'd42,  8'd128, 8'd212,
		8'd32,  8'd96,  8'd159, 8'd223,
		8'd26,  8'd76,  8'd128, 8'd178, 8'd230,
		8'd21,  8'd64,  8'd106, 8'd148, 8'd191, 8'd234,
		8'd18,  8'd55,  8'd91,  8'd128, 8'd164, 8'd200, 8'd237
	};

	// Directed requests: extremes, every short length, saturation, inversion and wrapping.
	seg_row_t directed_rows [NUM_ROWS] = '{
		'{1'b0, 16'h0000, 16'h0000, 8'd1,    8'd255, 32'h0000_0000, 1'b1, 8'd127},
		'{1'b1, 16'h0005, 16'h0007, 8'hFF,   8'd255, 32'hFFFF_FFFF, 1'b1, 8'd128},
		'{1'b0, 16'h1234, 16'h4321, 8'd1,    8'd0,   32'hA5A5_5A5A, 1'b1, 8'd0},
		'{1'b1, 16'h0001, 16'h0001, 8'd1,    8'd1,   32'h5A5A_A5A5, 1'b1, 8'd0},
		'{1'b0, 16'hFFFF, 16'h8000, 8'hFF,   8'd0,   32'h0F0F_F0F0, 1'b1, 8'd0},
		'{1'b1, 16'h0010, 16'h0020, 8'd0,    8'd200, 32'h1234_5678, 1'b0, 8'd0},
		'{1'b0, 16'h0100, 16'h0200, 8'd2,    8'd255, 32'h8765_4321, 1'b0, 8'd0},
		'{1'b1, 16'h0300, 16'h0400, 8'd3,    8'd137, 32'hCAFE_F00D, 1'b0, 8'd0},
		'{1'b0, 16'h0500, 16'h0600, 8'd4,    8'd255, 32'h0000_FFFF, 1'b0, 8'd0},
		'{1'b1, 16'h0700, 16'h0800, 8'd5,    8'd137, 32'hFFFF_0000, 1'b0, 8'd0},
		'{1'b0, 16'h0900, 16'h0A00, 8'd6,    8'd255, 32'h00FF_00FF, 1'b0, 8'd0},
		'{1'b1, 16'h0B00, 16'h0C00, 8'd7,    8'd137, 32'hFF00_FF00, 1'b0, 8'd0},
		'{1'b0, 16'h0D00, 16'h0E00, 8'd8,    8'd255, 32'h3333_CCCC, 1'b0, 8'd0},
		'{1'b1, 16'h0F00, 16'h1000, 8'hF9,   8'd255, 32'hCCCC_3333, 1'b0, 8'd0},
		'{1'b1, 16'h2000, 16'h3000, 8'd64,   8'd255, 32'h1111_1111, 1'b0, 8'd0},
		'{1'b0, 16'h4000, 16'h5000, 8'd65,   8'd200, 32'h2222_2222, 1'b0, 8'd0},
		'{1'b1, 16'h6000, 16'h7000, 8'd127,  8'd255, 32'h4444_4444, 1'b0, 8'd0},
		'{1'b0, 16'h7000, 16'h6000, 8'h80,   8'd255, 32'h8888_8888, 1'b0, 8'd0},
		'{1'b1, 16'h5000, 16'h4000, 8'hC0,   8'd99,  32'h7777_7777, 1'b0, 8'd0},
		'{1'b0, 16'h3000, 16'h2000, 8'hF8,   8'd255, 32'h6666_6666, 1'b0, 8'd0},
		'{1'b1, 16'h7FFC, 16'h0123, 8'd8,    8'd255, 32'hDEAD_BEEF, 1'b0, 8'd0},
		'{1'b0, 16'h0321, 16'hFFFE, 8'd5,    8'd180, 32'hBEEF_DEAD, 1'b0, 8'd0},
		'{1'b0, 16'h8000, 16'h7FFF, 8'd3,    8'd255, 32'hFEDC_BA98, 1'b0, 8'd0},
		'{1'b1, 16'hFFFD, 16'h8000, 8'd9,    8'd1,   32'h0123_4567, 1'b0, 8'd0},
		'{1'b0, 16'h7FF0, 16'hFFF0, 8'd20,   8'd128, 32'h89AB_CDEF, 1'b0, 8'd0}
	};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	pixel_t pending_pixels [$];
	int     mismatch_count = 0;
	int     tx_idle_pct    = 0;
	int     rx_stall_pct   = 0;
	int     hold_req       = 0;
	int     hold_ack       = 0;
	int     hold_left      = 0;

	antialias_edge_segment DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Expand one accepted request into the pixels it must produce, in order.
	function automatic void expand_segment(input seg_row_t r);
		int unsigned mag;
		int unsigned opa;
		int unsigned b;
		logic        inv;
		pixel_t      p;
		inv = r.len[7];
		mag = inv ? (256 - int'(r.len)) : int'(r.len);
		if (mag > BOUND_LEN)
			mag = BOUND_LEN;
		b = r.base;
		for (int unsigned i = 0; i < mag; i++) begin
			if (mag < 8)
				opa = (int'(RAMP_TAB[mag * (mag - 1) / 2 + i]) * b) >> 8;
			else
				opa = ((2 * i + 1) * b) / (2 * mag);
			if (inv)
				opa = b - opa;
			p.x     = r.dir ? r.x + 16'(i) : r.x;
			p.y     = r.dir ? r.y : r.y + 16'(i);
			p.opa   = 8'(opa);
			p.color = r.color;
			p.last  = (i + 1 == mag);
			pending_pixels.push_back(p);
		end
	endfunction

	// Coordinates mostly anywhere, often close to the signed or unsigned wrap point.
	function automatic logic [15:0] rand_coord();
		logic [15:0] c;
		c = 16'($urandom);
		case ($urandom_range(3, 0))
			0: c = 16'h7FF8 + 16'($urandom_range(15, 0));
			1: c = 16'hFFF8 + 16'($urandom_range(15, 0));
			default: ;
		endcase
		return c;
	endfunction

	// Random request: mostly short or medium ramps of either sign, some saturating, some empty.
	function automatic seg_row_t rand_segment();
		seg_row_t r;
		int       k;
		int       m;
		r.dir       = 1'($urandom);
		r.x         = rand_coord();
		r.y         = rand_coord();
		r.color     = $urandom;
		r.known     = 1'b0;
		r.known_opa = 8'd0;
		k = $urandom_range(15, 0);
		if (k == 0) begin
			r.len = 8'($urandom);
		end else if (k == 1) begin
			r.len = 8'd0;
		end else begin
			m = (k == 2) ? $urandom_range(66, 60) : $urandom_range(24, 1);
			r.len = $urandom_range(1, 0) ? 8'(0 - m) : 8'(m);
		end
		case ($urandom_range(7, 0))
			0: r.base = 8'd0;
			1: r.base = 8'd255;
			default: r.base = 8'($urandom);
		endcase
		return r;
	endfunction

	// Offer one request until it is taken, record its pixels, then maybe go idle a while.
	task automatic send_segment(input seg_row_t r);
		s_tdata  <= {r.color, r.base, r.len, r.y, r.x};
		s_tuser  <= r.dir;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (r.known)
			pending_pixels.push_back(pixel_t'{r.x, r.y, r.known_opa, r.color, 1'b1});
		else
			expand_segment(r);
		if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// Withdraw the request and wait until every expected pixel has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 40)
			$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
		end
	end

	// Check each pixel beat against the oldest expected pixel.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tdata[71:40], m_tlast};
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel x", 32'(got.x), 32'h0);
			end else begin
				want = pending_pixels.pop_front();
				if (got.x !== want.x)
					report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
				if (got.y !== want.y)
					report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
				if (got.opa !== want.opa)
					report_mismatch("pixel_opacity", 32'(got.opa), 32'(want.opa));
				if (got.color !== want.color)
					report_mismatch("color_out", got.color, want.color);
				if (got.last !== want.last)
					report_mismatch("last_pixel", 32'(got.last), 32'(want.last));
			end
		end
	end

	// Stimulus: directed table, then four stall phases of random segments.
	initial begin
		int tx_pct [4];
		int rx_pct [4];
		tx_pct = '{0, 46, 0, 35};
		rx_pct = '{0, 0, 46, 35};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_segment(directed_rows[i]);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			for (int n = 0; n < PHASE_SEGS; n++) begin
				// Long receiver hold-off while requests keep coming, to fill the queue.
				if (ph == 0 && n == 30)
					hold_req++;
				send_segment(rand_segment());
			end
			// The sender rests until every pixel of the phase has come out.
			wait_drained();
		end

		s_tvalid <= 1'b0;
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
